FILE: sv/csvf_pkg.sv
// Shared types, register indexes, mode codes and default sizes for the
// cascaded state variable filter. No dependencies.
package csvf_pkg;

   // default sizes, handed to the top level parameters
   localparam int CHANNEL_COUNT_DEF  = 2;
   localparam int MAX_STAGES_DEF     = 2;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // internal state format, signed Q8.24
   localparam int STATE_W         = 32;
   localparam int STATE_FRAC_BITS = 24;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A1     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A2     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A3     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DAMPING_K   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_MODE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TWO_STAGE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STATE_LIMIT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLED     = 3'd7;

   localparam logic [1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [1:0] MODE_BANDPASS = 2'd2;
   localparam logic [1:0] MODE_NOTCH    = 2'd3;

   typedef struct packed {
      logic [31:0] coef_a1;
      logic [31:0] coef_a2;
      logic [31:0] coef_a3;
      logic [31:0] damping_k;
      logic [1:0]  filter_mode;
      logic        two_stage;
      logic [30:0] state_limit;
      logic        enabled;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      coef_a1:     32'd268435456,
      coef_a2:     32'd0,
      coef_a3:     32'd0,
      damping_k:   32'd268435456,
      filter_mode: MODE_LOWPASS,
      two_stage:   1'b0,
      state_limit: 31'h7FFF_FFFF,
      enabled:     1'b1
   };

   // rounded product magnitude needs 64-frac bits; one sign bit, two of headroom
   function automatic int acc_width(input int coef_frac_bits);
      return 67 - coef_frac_bits;
   endfunction

endpackage

FILE: sv/csvf_if.sv
// Stream interfaces for the sample request and result channels.
// Depends on csvf_pkg for the default sample width.
interface csvf_req_if import csvf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface csvf_rsp_if import csvf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output channel_out, output sample_out, input ready);
   modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

FILE: sv/csvf_state_mem.sv
// Integrator state memory: one word {s1, s2} per stage and channel,
// registered read, valid bits so unwritten entries read zero. Uses csvf_pkg.
module csvf_state_mem import csvf_pkg::*; #(
   parameter int DEPTH = CHANNEL_COUNT_DEF * MAX_STAGES_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [2*STATE_W-1:0] wr_data,
   output logic [2*STATE_W-1:0] rd_data
);

   logic [2*STATE_W-1:0] ram_ff [DEPTH];
   logic [2*STATE_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   // never-written entries read as the reset state
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: sv/csvf_cmul.sv
// Shared coefficient multiplier: unsigned coefficient times signed state,
// rounded half away from zero. Two register stages. Uses csvf_pkg.
module csvf_cmul import csvf_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int ACC_W = acc_width(COEF_FRAC_BITS)
) (
   input  logic                    clock,
   input  logic [31:0]             coef,
   input  logic signed [STATE_W-1:0] value,
   output logic signed [ACC_W-1:0] term
);

   localparam int RND_W = 64 - COEF_FRAC_BITS;
   localparam logic [63:0] HALF = 64'd1 << (COEF_FRAC_BITS - 1);

   logic [31:0]             mag;
   logic [63:0]             prod_ff;
   logic                    neg_ff;
   logic [63:0]             prod_rnd;
   logic [RND_W-1:0]        rnd;
   logic signed [ACC_W-1:0] rnd_ext;
   logic signed [ACC_W-1:0] term_in;
   logic signed [ACC_W-1:0] term_ff;

   // magnitude of the most negative state is 2^31, still fits unsigned
   assign mag = value[STATE_W-1] ? 32'(-value) : 32'(value);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(coef) * 64'(mag);
      neg_ff  <= value[STATE_W-1];
   end

   assign prod_rnd = prod_ff + HALF;
   assign rnd      = RND_W'(prod_rnd >> COEF_FRAC_BITS);
   assign rnd_ext  = ACC_W'(rnd);
   assign term_in  = neg_ff ? -rnd_ext : rnd_ext;

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

FILE: sv/csvf_core.sv
// Filter sequencer and datapath: reads a stage's states, runs the SVF update
// through the shared multiplier, writes back and forms the response.
// Uses csvf_pkg, csvf_cmul and csvf_state_mem.
module csvf_core import csvf_pkg::*; #(
   parameter int CHANNEL_COUNT  = CHANNEL_COUNT_DEF,
   parameter int MAX_STAGES     = MAX_STAGES_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_chan,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_chan,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int DEPTH  = MAX_STAGES * CHANNEL_COUNT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACC_W  = acc_width(COEF_FRAC_BITS);

   // sample <-> state format alignment
   localparam int SHIFT = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int UP    = (SHIFT > 0) ? SHIFT : 0;
   localparam int DN    = (SHIFT < 0) ? -SHIFT : 0;
   localparam int OUT_W = 34 + DN;
   localparam logic signed [OUT_W-1:0] ROUND_HALF =
      OUT_W'((UP > 0) ? (64'sd1 <<< ((UP > 0) ? UP - 1 : 0)) : 64'sd0);
   localparam logic signed [OUT_W-1:0] OUT_HI = OUT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // stage schedule; a product issued at one step reaches term through both csvf_cmul registers
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_READ  = 4'd0; // state read
   localparam logic [STEP_W-1:0] STEP_V3    = 4'd1; // v3, issue a1*s1
   localparam logic [STEP_W-1:0] STEP_A2V3  = 4'd2; // issue a2*v3
   localparam logic [STEP_W-1:0] STEP_V1A   = 4'd3; // issue a2*s1, acc = a1*s1
   localparam logic [STEP_W-1:0] STEP_V1B   = 4'd4; // issue a3*v3, v1
   localparam logic [STEP_W-1:0] STEP_V2A   = 4'd5; // issue k*v1, acc = s2 + a2*s1, s1'
   localparam logic [STEP_W-1:0] STEP_V2B   = 4'd6; // v2
   localparam logic [STEP_W-1:0] STEP_RESP  = 4'd7; // s2', stage response
   localparam logic [STEP_W-1:0] STEP_WRITE = 4'd8; // write back, next stage or finish
   localparam int READ_TO_WRITE = 8;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
      else if (v < SAT_MIN) r = 32'sh8000_0000;
      else r = 32'(v);
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] ext(input logic signed [31:0] v);
      return ACC_W'(v);
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              stage_ff, stage_in;

   logic                          chan_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff;
   logic signed [31:0]            cur_ff, v3_ff, v1_ff, v2_ff, n1_ff, n2_ff;
   logic signed [ACC_W-1:0]       acc_ff;

   logic                    accept, running, last_stage;
   logic [ADDR_W-1:0]       addr;
   logic                    ch_sel;
   logic                    rd_en, wr_en, clear;
   logic [2*STATE_W-1:0]    wr_data, rd_data;
   logic signed [31:0]      s1, s2;
   logic [31:0]             mul_coef;
   logic signed [31:0]      mul_value;
   logic signed [ACC_W-1:0] term;
   logic signed [31:0]      resp;
   logic signed [63:0]      x_wide;
   logic signed [31:0]      cur_init;
   logic signed [OUT_W-1:0] out_wide;
   logic signed [SAMPLE_BITS-1:0] out_sat;

   assign accept     = in_valid && in_ready;
   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = (state_ff == ST_DONE);
   assign running    = (state_ff == ST_RUN);
   assign last_stage = stage_ff || !(cfg.two_stage && (MAX_STAGES >= 2));

   // channel wraps modulo the channel count for state selection
   assign ch_sel = (CHANNEL_COUNT > 1) ? chan_ff : 1'b0;
   assign addr   = ADDR_W'(int'(stage_ff) * CHANNEL_COUNT + int'(ch_sel));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cfg.enabled) begin
                  state_in = ST_RUN;
                  step_in  = STEP_READ;
                  stage_in = 1'b0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_WRITE) begin
               if (last_stage) begin
                  state_in = ST_DONE;
               end else begin
                  stage_in = 1'b1;
                  step_in  = STEP_READ;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_READ;
         stage_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         stage_ff <= stage_in;
      end
   end

   // sample to Q8.24
   assign x_wide   = 64'(in_sample);
   assign cur_init = 32'((x_wide <<< UP) >>> DN);

   // Q8.24 back to sample, half rounds up, then saturate
   assign out_wide = ((OUT_W'(cur_ff) + ROUND_HALF) >>> UP) <<< DN;
   assign out_sat  = (out_wide > OUT_HI) ? SAMPLE_BITS'(OUT_HI) :
                     (out_wide < OUT_LO) ? SAMPLE_BITS'(OUT_LO) : SAMPLE_BITS'(out_wide);

   assign s1 = rd_data[2*STATE_W-1:STATE_W];
   assign s2 = rd_data[STATE_W-1:0];

   always_comb begin
      unique case (step_ff)
         STEP_V3:   begin mul_coef = cfg.coef_a1;   mul_value = s1;    end
         STEP_A2V3: begin mul_coef = cfg.coef_a2;   mul_value = v3_ff; end
         STEP_V1A:  begin mul_coef = cfg.coef_a2;   mul_value = s1;    end
         STEP_V1B:  begin mul_coef = cfg.coef_a3;   mul_value = v3_ff; end
         STEP_V2A:  begin mul_coef = cfg.damping_k; mul_value = v1_ff; end
         default:   begin mul_coef = cfg.coef_a1;   mul_value = s1;    end
      endcase
   end

   always_comb begin
      unique case (cfg.filter_mode)
         MODE_LOWPASS:  resp = v2_ff;
         MODE_HIGHPASS: resp = sat32(ext(cur_ff) - term - ext(v2_ff));
         MODE_BANDPASS: resp = v1_ff;
         MODE_NOTCH:    resp = sat32(ext(cur_ff) - ext(v1_ff));
         default:       resp = v2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff <= in_chan;
         cur_ff  <= cur_init;
         res_ff  <= in_sample;
      end
      if (running) begin
         unique case (step_ff)
            STEP_V3:  v3_ff  <= sat32(ext(cur_ff) - ext(s2));
            STEP_V1A: acc_ff <= term;
            STEP_V1B: v1_ff  <= sat32(acc_ff + term);
            STEP_V2A: begin
               acc_ff <= ext(s2) + term;
               n1_ff  <= sat32((ext(v1_ff) <<< 1) - ext(s1));
            end
            STEP_V2B: v2_ff <= sat32(acc_ff + term);
            STEP_RESP: begin
               n2_ff  <= sat32((ext(v2_ff) <<< 1) - ext(s2));
               cur_ff <= resp;
            end
            STEP_WRITE: begin
               if (last_stage) res_ff <= out_sat;
            end
            default: ;
         endcase
      end
   end

   // runaway guard: either state past the limit clears both
   assign clear   = (mag32(n1_ff) > {1'b0, cfg.state_limit}) ||
                    (mag32(n2_ff) > {1'b0, cfg.state_limit});
   assign wr_data = clear ? '0 : {n1_ff, n2_ff};
   assign rd_en   = running && (step_ff == STEP_READ);
   assign wr_en   = running && (step_ff == STEP_WRITE);

   csvf_cmul #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_cmul (
      .clock (clock),
      .coef  (mul_coef),
      .value (mul_value),
      .term  (term)
   );

   csvf_state_mem #(
      .DEPTH(DEPTH)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign out_chan   = chan_ff;
   assign out_sample = res_ff;

   a_bypass_next: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg.enabled) |=> out_valid)
      else $error("bypassed beat not presented next cycle");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (accept && cfg.enabled) |=> (running && step_ff == STEP_READ && !stage_ff))
      else $error("filtered beat did not start at first stage read");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> $past(rd_en, READ_TO_WRITE))
      else $error("state write not aligned with its read");

   a_second_stage: assert property (@(posedge clock) disable iff (reset)
      (running && stage_ff) |-> (cfg.two_stage && (MAX_STAGES >= 2)))
      else $error("second stage run without cascade");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(res_ff) && $stable(chan_ff)))
      else $error("result changed while stalled");

endmodule

FILE: sv/cascaded_state_variable_filter_unit.sv
// Cascaded stereo SVF: configuration registers, filter core, result register.
// Each request beat runs its stages in turn on the shared multiplier (or bypasses them
// when disabled); a new beat is taken only once the last result is in the result register.
// Synchronous active-high reset restores register defaults and zeroes all states.
// Uses csvf_pkg, csvf_if and csvf_core.
module cascaded_state_variable_filter_unit import csvf_pkg::*; #(
   parameter int CHANNEL_COUNT  = CHANNEL_COUNT_DEF,
   parameter int MAX_STAGES     = MAX_STAGES_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   csvf_req_if.sink               req_bus,
   csvf_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                          core_out_valid;
   logic                          core_out_ready;
   logic                          core_out_chan;
   logic signed [SAMPLE_BITS-1:0] core_out_sample;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_chan_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_COEF_A1:     cfg_in.coef_a1     = csr_data;
            REG_COEF_A2:     cfg_in.coef_a2     = csr_data;
            REG_COEF_A3:     cfg_in.coef_a3     = csr_data;
            REG_DAMPING_K:   cfg_in.damping_k   = csr_data;
            REG_FILTER_MODE: cfg_in.filter_mode = csr_data[1:0];
            REG_TWO_STAGE:   cfg_in.two_stage   = csr_data[0];
            REG_STATE_LIMIT: cfg_in.state_limit = csr_data[30:0];
            REG_ENABLED:     cfg_in.enabled     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csvf_core #(
      .CHANNEL_COUNT  (CHANNEL_COUNT),
      .MAX_STAGES     (MAX_STAGES),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_chan    (req_bus.channel),
      .in_sample  (req_bus.sample_in),
      .out_valid  (core_out_valid),
      .out_ready  (core_out_ready),
      .out_chan   (core_out_chan),
      .out_sample (core_out_sample)
   );

   // output register lets the core take the next beat while a result waits
   assign core_out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load       = core_out_valid && core_out_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chan_ff   <= core_out_chan;
         rsp_sample_ff <= core_out_sample;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.channel_out = rsp_chan_ff;
   assign rsp_bus.sample_out  = rsp_sample_ff;

endmodule

FILE: verif/csvf_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the cascaded stereo SVF: follows register writes, predicts
// every result beat from the accepted request beats and compares them in order.
// Depends on csvf_pkg and the csvf_req_if / csvf_rsp_if interfaces.
module csvf_response_checker import csvf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   csvf_req_if                    req_bus,
   csvf_rsp_if                    rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam int CHANNELS = CHANNEL_COUNT_DEF;
   localparam int STAGES   = MAX_STAGES_DEF;
   localparam int SBITS    = SAMPLE_BITS_DEF;
   localparam int CFRAC    = COEF_FRAC_BITS_DEF;
   // sample to state alignment, Q1.23 -> Q8.24
   localparam int ALIGN    = STATE_FRAC_BITS - (SBITS - 1);

   localparam longint WORD_MAX   = 64'sd2147483647;
   localparam longint WORD_MIN   = -64'sd2147483648;
   localparam longint SAMPLE_TOP = (longint'(1) << (SBITS - 1)) - 1;

   typedef struct {
      logic                    channel;
      logic signed [SBITS-1:0] sample;
   } result_beat_type;

   cfg_type         settings;
   longint          first_integ  [STAGES*CHANNELS];
   longint          second_integ [STAGES*CHANNELS];
   result_beat_type expected_results [$];
   result_beat_type want;

   function automatic longint clip32(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // unsigned coefficient times signed value, rounded half away from zero
   function automatic longint coef_mult(input logic [31:0] coef, input longint v);
      logic [63:0] mag;
      logic [63:0] prod;
      mag  = (v < 0) ? 64'(-v) : 64'(v);
      prod = ({32'd0, coef} * mag + (64'd1 << (CFRAC - 1))) >> CFRAC;
      return (v < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic logic signed [SBITS-1:0] filter_sample(
      input logic                    channel,
      input logic signed [SBITS-1:0] x
   );
      longint cur, s1, s2, v1, v2, v3, n1, n2, y;
      int     stages, st, idx;
      if (!settings.enabled) return x;
      stages = (settings.two_stage && STAGES >= 2) ? 2 : 1;
      cur    = clip32(longint'(x) * (longint'(1) << ALIGN));
      for (st = 0; st < stages; st++) begin
         idx = st * CHANNELS + (int'(channel) % CHANNELS);
         s1  = first_integ[idx];
         s2  = second_integ[idx];
         v3  = clip32(cur - s2);
         v1  = clip32(coef_mult(settings.coef_a1, s1) + coef_mult(settings.coef_a2, v3));
         v2  = clip32(s2 + coef_mult(settings.coef_a2, s1)
                      + coef_mult(settings.coef_a3, v3));
         n1  = clip32(2 * v1 - s1);
         n2  = clip32(2 * v2 - s2);
         // runaway guard: wipe both integrators, response still uses v1/v2
         if ((n1 < 0 ? -n1 : n1) > longint'(settings.state_limit) ||
             (n2 < 0 ? -n2 : n2) > longint'(settings.state_limit)) begin
            n1 = 0;
            n2 = 0;
         end
         first_integ[idx]  = n1;
         second_integ[idx] = n2;
         case (settings.filter_mode)
            MODE_LOWPASS:  cur = v2;
            MODE_HIGHPASS: cur = clip32(cur - coef_mult(settings.damping_k, v1) - v2);
            MODE_BANDPASS: cur = v1;
            default:       cur = clip32(cur - v1);
         endcase
      end
      y = (cur + (longint'(1) << (ALIGN - 1))) >>> ALIGN;
      if (y > SAMPLE_TOP) y = SAMPLE_TOP;
      if (y < -SAMPLE_TOP - 1) y = -SAMPLE_TOP - 1;
      return y[SBITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: MISMATCH %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings = CFG_RESET;
         for (int i = 0; i < STAGES*CHANNELS; i++) begin
            first_integ[i]  = 0;
            second_integ[i] = 0;
         end
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_COEF_A1:     settings.coef_a1     = csr_data;
               REG_COEF_A2:     settings.coef_a2     = csr_data;
               REG_COEF_A3:     settings.coef_a3     = csr_data;
               REG_DAMPING_K:   settings.damping_k   = csr_data;
               REG_FILTER_MODE: settings.filter_mode = csr_data[1:0];
               REG_TWO_STAGE:   settings.two_stage   = csr_data[0];
               REG_STATE_LIMIT: settings.state_limit = csr_data[30:0];
               REG_ENABLED:     settings.enabled     = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result beat ch %0d sample %0d with nothing expected",
                                         rsp_bus.channel_out, rsp_bus.sample_out));
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.channel_out !== want.channel)
                  report_mismatch($sformatf("channel_out %0d, expected %0d",
                                            rsp_bus.channel_out, want.channel));
               if (rsp_bus.sample_out !== want.sample)
                  report_mismatch($sformatf("ch %0d sample_out %0d, expected %0d",
                                            want.channel, rsp_bus.sample_out, want.sample));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want.channel = req_bus.channel;
            want.sample  = filter_sample(req_bus.channel, req_bus.sample_in);
            expected_results.push_back(want);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the cascaded stereo SVF: clock, reset, register settings,
// sample beats and result back-pressure; verdict from csvf_response_checker.
// Depends on csvf_pkg, csvf_if and cascaded_state_variable_filter_unit.
module tb;
   import csvf_pkg::*;

   localparam int SBITS        = SAMPLE_BITS_DEF;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 40;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 125;
   localparam logic signed [SBITS-1:0] SAMPLE_MAX = {1'b0, {(SBITS-1){1'b1}}};
   localparam logic signed [SBITS-1:0] SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     mismatch_count;
   int                     pending_count;
   int                     idle_cycles = 0;
   bit                     steady = 1'b0;

   csvf_req_if req_bus ();
   csvf_rsp_if rsp_bus ();

   cascaded_state_variable_filter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   csvf_response_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
   end

   // cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [SBITS-1:0] extreme_sample(input int i);
      case (i % 5)
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return SBITS'(1);
         default: return '1;
      endcase
   endfunction

   function automatic logic [31:0] to_q4_28(input real r);
      return 32'(longint'(r * real'(longint'(1) << COEF_FRAC_BITS_DEF)));
   endfunction

   // stable filter from prewarped gain g and damping k
   function automatic cfg_type tuned_filter(input real g, input real k);
      cfg_type c;
      real     a1;
      c           = CFG_RESET;
      a1          = 1.0 / (1.0 + g * (g + k));
      c.coef_a1   = to_q4_28(a1);
      c.coef_a2   = to_q4_28(g * a1);
      c.coef_a3   = to_q4_28(g * g * a1);
      c.damping_k = to_q4_28(k);
      return c;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int      kind;
      kind = $urandom_range(9);
      if (kind < 6) begin
         c = tuned_filter(real'($urandom_range(1, 3000)) / 1000.0,
                          real'($urandom_range(20, 2000)) / 1000.0);
      end else if (kind < 8) begin
         c = CFG_RESET;
         c.coef_a1   = $urandom;
         c.coef_a2   = $urandom;
         c.coef_a3   = $urandom;
         c.damping_k = $urandom;
      end else begin
         c = CFG_RESET;
         c.coef_a1   = $urandom_range(1) ? '1 : '0;
         c.coef_a2   = $urandom_range(1) ? '1 : '0;
         c.coef_a3   = $urandom_range(1) ? '1 : '0;
         c.damping_k = $urandom_range(1) ? '1 : '0;
      end
      c.filter_mode = 2'($urandom_range(3));
      c.two_stage   = 1'($urandom_range(1));
      c.enabled     = ($urandom_range(9) != 0);
      case ($urandom_range(9))
         0:       c.state_limit = '0;
         1:       c.state_limit = 31'($urandom_range(32'h0100_0000));
         2, 3:    c.state_limit = 31'($urandom);
         default: c.state_limit = '1;
      endcase
      return c;
   endfunction

   task automatic send_sample(input logic ch, input logic signed [SBITS-1:0] x);
      while (!steady && $urandom_range(99) < 6) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.sample_in <= x;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   task automatic apply_settings(input cfg_type c);
      drain();
      write_reg(REG_COEF_A1, c.coef_a1);
      write_reg(REG_COEF_A2, c.coef_a2);
      write_reg(REG_COEF_A3, c.coef_a3);
      write_reg(REG_DAMPING_K, c.damping_k);
      write_reg(REG_FILTER_MODE, CSR_DATA_W'(c.filter_mode));
      write_reg(REG_TWO_STAGE, CSR_DATA_W'(c.two_stage));
      write_reg(REG_STATE_LIMIT, CSR_DATA_W'(c.state_limit));
      write_reg(REG_ENABLED, CSR_DATA_W'(c.enabled));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_extremes(input int count);
      for (int i = 0; i < count; i++)
         send_sample(1'(i), extreme_sample(i));
   endtask

   initial begin
      cfg_type                 setting;
      logic                    ch;
      logic signed [SBITS-1:0] last_in [2];

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      req_bus.valid     = 1'b0;
      req_bus.channel   = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready     = 1'b0;
      last_in[0]        = '0;
      last_in[1]        = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-up settings untouched
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);

      setting = tuned_filter(0.5, 1.0);
      apply_settings(setting);
      send_extremes(5);
      setting.filter_mode = MODE_HIGHPASS;
      apply_settings(setting);
      send_extremes(3);
      setting.filter_mode = MODE_BANDPASS;
      apply_settings(setting);
      send_extremes(3);
      setting.filter_mode = MODE_NOTCH;
      apply_settings(setting);
      send_extremes(3);

      setting.filter_mode = MODE_LOWPASS;
      setting.two_stage   = 1'b1;
      apply_settings(setting);
      send_extremes(2);

      // zero limit: any non-zero state wipes the stage
      setting.state_limit = '0;
      apply_settings(setting);
      send_extremes(2);

      // full-scale coefficients drive large sums, some into saturation
      setting.coef_a1     = '1;
      setting.coef_a2     = '1;
      setting.coef_a3     = '1;
      setting.damping_k   = '1;
      setting.filter_mode = MODE_HIGHPASS;
      setting.state_limit = '1;
      apply_settings(setting);
      send_extremes(2);

      setting.enabled = 1'b0;
      apply_settings(setting);
      send_extremes(2);

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(random_settings());
         steady = (phase == 5 || phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ch = 1'($urandom_range(1));
            case ($urandom_range(9))
               0, 1, 2: ; // hold the channel's last value so the filter settles
               3:       last_in[ch] = extreme_sample($urandom_range(4));
               4, 5:    last_in[ch] = SBITS'(int'($urandom_range(8191)) - 4096);
               default: last_in[ch] = SBITS'($urandom);
            endcase
            send_sample(ch, last_in[ch]);
         end
      end
      steady = 1'b0;

      drain();
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
